// ----- rtl/core/led_brightness_command_engine_assert.svh -----
// ----------------------------------------------------------------------------
// LED brightness command engine - assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef LED_BRIGHTNESS_COMMAND_ENGINE_ASSERT_SVH
`define LED_BRIGHTNESS_COMMAND_ENGINE_ASSERT_SVH

// same-cycle implication, off during reset
`define LBCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbce port check failed");

// next-cycle implication, off during reset
`define LBCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbce port check failed");

`endif

// ----- rtl/core/lbce_pkg.sv -----
// ----------------------------------------------------------------------------
// lbce_pkg
// Types and constants of the LED brightness command engine.
// ----------------------------------------------------------------------------
package lbce_pkg;

  localparam int CHANNELS   = 144;
  localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_CW      = $clog2(CHANNELS + 1);
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_ENABLE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL   = 4'd1;

  localparam logic [6:0] MIN_INTERVAL_RST = 7'd30;

  // command modes
  localparam logic [7:0] MODE_DEC_ONE = 8'd0;
  localparam logic [7:0] MODE_INC_ONE = 8'd1;
  localparam logic [7:0] MODE_SET_ONE = 8'd2;
  localparam logic [7:0] MODE_DEC_ALL = 8'd3;
  localparam logic [7:0] MODE_INC_ALL = 8'd4;
  localparam logic [7:0] MODE_SET_ALL = 8'd5;

  // per-channel operations
  localparam logic [1:0] OP_DEC = 2'd0;
  localparam logic [1:0] OP_INC = 2'd1;

  // trigger codes that are dropped
  localparam logic [7:0] KIND_SWITCH   = 8'h00;
  localparam logic [7:0] PHASE_RELEASE = 8'h03;
  localparam logic [7:0] KIND_QUERY    = 8'hFF;
  localparam logic [7:0] PHASE_QUERY   = 8'hFF;

  typedef struct packed {
    logic [7:0]  now_ms;
    logic [7:0]  trigger_kind;
    logic [7:0]  trigger_phase;
    logic [7:0]  mode;
    logic [7:0]  amount;
    logic [15:0] index;
  } in_cmd_t;

  typedef struct packed {
    logic        accepted;
    logic        forward;
    logic [15:0] forward_index;
    logic        applied_locally;
    logic        index_error;
    logic [7:0]  channel_value;
  } out_res_t;

endpackage

// ----- rtl/core/led_brightness_command_engine.sv -----
// ----------------------------------------------------------------------------
// led_brightness_command_engine
// Takes one LED command word on in_*, filters releases, queries and
// commands that come too soon after the last accepted one, updates the
// brightness store and returns one result word on out_*.
// Config writes on cfg_* (always ready) set forward enable and the minimum
// interval; write them only while the engine is idle.
// One command at a time: in_ready is high only in idle. A dropped command
// goes from the check straight to the result; a local one-channel command
// reads and then writes its channel; an all-channel command sweeps the
// store, one read and one write per cycle, then reads back the indexed
// channel if it is local. The next word is taken once the result has gone
// to the output register.
// The result sits in an output register; a new command is taken while it
// waits. If out_ready stays low with a second result done, the engine holds
// that result and stays busy until the register frees up.
// Reset clears control state, the config registers and the store valid bits,
// so every channel reads zero after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module led_brightness_command_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lbce_pkg::in_cmd_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lbce_pkg::out_res_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lbce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbce_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lbce_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CHECK = 8'b0000_0010,
    ST_RD    = 8'b0000_0100,
    ST_WR    = 8'b0000_1000,
    ST_SWEEP = 8'b0001_0000,
    ST_VRD   = 8'b0010_0000,
    ST_VCAP  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  function automatic logic [7:0] apply_op(input logic [7:0] old_v,
                                          input logic [1:0] op,
                                          input logic [7:0] amt);
    logic [7:0] r;
    case (op)
      OP_DEC:  r = old_v - amt;
      OP_INC:  r = old_v + amt;
      default: r = amt;
    endcase
    return r;
  endfunction

  state_t              state_r, state_nxt;
  in_cmd_t             cmd_r, cmd_nxt;
  out_res_t            res_r, res_nxt;
  out_res_t            out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CH_CW-1:0]    cnt_r, cnt_nxt;
  logic [7:0]          last_ms_r, last_ms_nxt;
  logic                fwd_en_r;
  logic [6:0]          min_iv_r;

  logic [7:0]          mem [CHANNELS];
  logic [CHANNELS-1:0] vld_r;
  logic [7:0]          rd_data_r;
  logic                rd_vld_r;

  logic                rd_en, wr_en;
  logic [CH_AW-1:0]    rd_addr, wr_addr;
  logic [7:0]          wr_data;

  logic                idx_local, is_drop_evt, too_soon, mode_one, mode_all;
  logic [CH_AW-1:0]    idx_addr;
  logic [6:0]          gap;
  logic [CH_CW-1:0]    cnt_m1;
  logic [1:0]          op;
  logic [7:0]          old_val, new_val;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign idx_local   = cmd_r.index < 16'(CHANNELS);
  assign idx_addr    = cmd_r.index[CH_AW-1:0];
  assign is_drop_evt = ((cmd_r.trigger_kind == KIND_QUERY) &&
                        (cmd_r.trigger_phase == PHASE_QUERY)) ||
                       ((cmd_r.trigger_kind == KIND_SWITCH) &&
                        (cmd_r.trigger_phase == PHASE_RELEASE));
  // 7-bit wrapping time distance
  assign gap      = 7'(cmd_r.now_ms - last_ms_r);
  assign too_soon = gap < min_iv_r;
  assign mode_one = cmd_r.mode <= MODE_SET_ONE;
  assign mode_all = !mode_one && (cmd_r.mode <= MODE_SET_ALL);

  assign cnt_m1  = cnt_r - CH_CW'(1);
  assign op      = (state_r == ST_SWEEP) ? 2'(cmd_r.mode - MODE_DEC_ALL)
                                         : cmd_r.mode[1:0];
  assign old_val = rd_vld_r ? rd_data_r : 8'h00;
  assign new_val = apply_op(old_val, op, cmd_r.amount);

  // store port control: sweep reads channel n while writing channel n-1
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_addr;
    wr_en   = 1'b0;
    wr_addr = idx_addr;
    wr_data = new_val;
    case (state_r)
      ST_RD, ST_VRD: begin
        rd_en = 1'b1;
      end
      ST_WR: begin
        wr_en = 1'b1;
      end
      ST_SWEEP: begin
        rd_en   = cnt_r < CH_CW'(CHANNELS);
        rd_addr = cnt_r[CH_AW-1:0];
        wr_en   = cnt_r != '0;
        wr_addr = cnt_m1[CH_AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_en_r <= 1'b0;
      min_iv_r <= MIN_INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FORWARD_ENABLE: fwd_en_r <= cfg_data[0];
        REG_MIN_INTERVAL:   min_iv_r <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    res_nxt       = res_r;
    cnt_nxt       = cnt_r;
    last_ms_nxt   = last_ms_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        res_nxt   = '0;
        state_nxt = ST_DONE;
        if (!is_drop_evt && !too_soon) begin
          last_ms_nxt      = cmd_r.now_ms;
          res_nxt.accepted = 1'b1;
          if (mode_one) begin
            if (idx_local) begin
              res_nxt.applied_locally = 1'b1;
              state_nxt               = ST_RD;
            end else if (fwd_en_r) begin
              res_nxt.forward       = 1'b1;
              res_nxt.forward_index = cmd_r.index - 16'(CHANNELS);
            end else begin
              res_nxt.index_error = 1'b1;
            end
          end else if (mode_all) begin
            res_nxt.applied_locally = 1'b1;
            res_nxt.forward         = fwd_en_r;
            res_nxt.forward_index   = fwd_en_r ? cmd_r.index : 16'h0000;
            cnt_nxt                 = '0;
            state_nxt               = ST_SWEEP;
          end else if (idx_local) begin
            state_nxt = ST_VRD;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_WR;
      end
      ST_WR: begin
        res_nxt.channel_value = new_val;
        state_nxt             = ST_DONE;
      end
      ST_SWEEP: begin
        cnt_nxt = cnt_r + CH_CW'(1);
        if (cnt_r == CH_CW'(CHANNELS)) begin
          state_nxt = idx_local ? ST_VRD : ST_DONE;
        end
      end
      ST_VRD: begin
        state_nxt = ST_VCAP;
      end
      ST_VCAP: begin
        res_nxt.channel_value = old_val;
        state_nxt             = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      last_ms_r   <= 8'h00;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_ms_r   <= last_ms_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

endmodule

// ----- rtl/core/lbce_checker.sv -----
// ----------------------------------------------------------------------------
// lbce_checker
// Port-level checks for the LED brightness command engine, bound to the top.
// ----------------------------------------------------------------------------
`include "led_brightness_command_engine_assert.svh"

module lbce_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input lbce_pkg::out_res_t out_data
);
  import lbce_pkg::*;

  `LBCE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // one command in flight: busy right after an accept
  `LBCE_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // an out-of-range index with forwarding off touches nothing and is not forwarded
  `LBCE_ASSERT_IMP(a_err_excl, clk, rst_n, out_valid && out_data.index_error, !out_data.applied_locally && !out_data.forward && (out_data.channel_value == 8'h00))

  // a dropped word carries all-zero fields
  `LBCE_ASSERT_IMP(a_drop_clean, clk, rst_n, out_valid && !out_data.accepted, !out_data.forward && !out_data.applied_locally && !out_data.index_error && (out_data.forward_index == 16'h0000) && (out_data.channel_value == 8'h00))

endmodule

bind led_brightness_command_engine lbce_checker u_lbce_checker (.*);

// ----- sim/lbce_result_checker.sv -----
// ----------------------------------------------------------------------------
// lbce_result_checker
// Watches the command, result and register ports of the LED brightness
// command engine. Keeps its own copy of the brightness levels, the last
// accepted time stamp and the two registers, works out the result word of
// each command taken, and compares the result words in order.
// ----------------------------------------------------------------------------
module lbce_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  lbce_pkg::in_cmd_t               in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  lbce_pkg::out_res_t              out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [lbce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbce_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              outstanding,
  output int                              n_accepted,
  output int                              n_forwarded,
  output int                              n_index_err
);
  timeunit 1ns;
  timeprecision 1ps;
  import lbce_pkg::*;

  logic [7:0] level_mirror [CHANNELS];
  logic [7:0] last_ms;
  logic       fwd_en;
  logic [6:0] min_gap;
  out_res_t   outcome_q [$];
  int         bad_cnt  = 0;
  int         seen_cnt = 0;
  int         acc_cnt  = 0;
  int         fwd_cnt  = 0;
  int         err_cnt  = 0;

  function automatic logic [7:0] step_level(logic [7:0] old, logic [7:0] op,
                                            logic [7:0] amt);
    case (op)
      MODE_DEC_ONE: return old - amt;
      MODE_INC_ONE: return old + amt;
      default:      return amt;
    endcase
  endfunction

  // updates the mirrored state and returns the result word the command causes
  function automatic out_res_t command_outcome(in_cmd_t c);
    out_res_t r;
    logic [6:0] gap;
    r = '0;
    if (c.trigger_kind == KIND_QUERY && c.trigger_phase == PHASE_QUERY) return r;
    if (c.trigger_kind == KIND_SWITCH && c.trigger_phase == PHASE_RELEASE) return r;
    gap = 7'(c.now_ms - last_ms);
    if (gap < min_gap) return r;
    last_ms    = c.now_ms;
    r.accepted = 1'b1;
    if (c.mode <= MODE_SET_ONE) begin
      if (c.index >= CHANNELS) begin
        if (fwd_en) begin
          r.forward       = 1'b1;
          r.forward_index = c.index - 16'(CHANNELS);
        end else begin
          r.index_error = 1'b1;
        end
      end else begin
        level_mirror[c.index] = step_level(level_mirror[c.index], c.mode, c.amount);
        r.applied_locally     = 1'b1;
      end
    end else if (c.mode <= MODE_SET_ALL) begin
      // all-channel modes map onto the one-channel operations
      for (int ch = 0; ch < CHANNELS; ch++)
        level_mirror[ch] = step_level(level_mirror[ch], 8'(c.mode - MODE_DEC_ALL),
                                      c.amount);
      r.applied_locally = 1'b1;
      if (fwd_en) begin
        r.forward       = 1'b1;
        r.forward_index = c.index;
      end
    end
    if (c.index < CHANNELS) r.channel_value = level_mirror[c.index];
    return r;
  endfunction

  function automatic string field_diffs(out_res_t want, out_res_t got);
    string s;
    s = "";
    if (got.accepted !== want.accepted)
      s = {s, $sformatf(" accepted exp %0d got %0d", want.accepted, got.accepted)};
    if (got.forward !== want.forward)
      s = {s, $sformatf(" forward exp %0d got %0d", want.forward, got.forward)};
    if (got.forward_index !== want.forward_index)
      s = {s, $sformatf(" forward_index exp %0d got %0d", want.forward_index,
                        got.forward_index)};
    if (got.applied_locally !== want.applied_locally)
      s = {s, $sformatf(" applied_locally exp %0d got %0d", want.applied_locally,
                        got.applied_locally)};
    if (got.index_error !== want.index_error)
      s = {s, $sformatf(" index_error exp %0d got %0d", want.index_error,
                        got.index_error)};
    if (got.channel_value !== want.channel_value)
      s = {s, $sformatf(" channel_value exp %0d got %0d", want.channel_value,
                        got.channel_value)};
    return s;
  endfunction

  always @(posedge clk) begin
    out_res_t want;
    string    diffs;
    if (!rst_n) begin
      foreach (level_mirror[ch]) level_mirror[ch] = '0;
      last_ms = '0;
      fwd_en  = 1'b0;
      min_gap = MIN_INTERVAL_RST;
      outcome_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FORWARD_ENABLE: fwd_en  = cfg_data[0];
          REG_MIN_INTERVAL:   min_gap = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = command_outcome(in_data);
        outcome_q.push_back(want);
        if (want.accepted) acc_cnt++;
        if (want.forward) fwd_cnt++;
        if (want.index_error) err_cnt++;
      end
      if (out_valid && out_ready) begin
        seen_cnt++;
        if (outcome_q.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("[%0t] result word %0d with nothing expected: %h", $time,
                     seen_cnt, out_data);
        end else begin
          want  = outcome_q.pop_front();
          diffs = field_diffs(want, out_data);
          if (diffs != "") begin
            bad_cnt++;
            if (bad_cnt <= 10)
              $display("[%0t] result word %0d wrong:%s", $time, seen_cnt, diffs);
          end
        end
      end
    end
    outstanding <= outcome_q.size();
    mismatches  <= bad_cnt;
    n_accepted  <= acc_cnt;
    n_forwarded <= fwd_cnt;
    n_index_err <= err_cnt;
  end

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the LED brightness command engine: a directed set of commands that
// hit drops, wrap-around, bad and remote indexes and every mode, then random
// commands under several register settings, with random stalls on both
// channels. The result checker beside the engine does the comparing.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lbce_pkg::*;

  localparam logic [7:0] KIND_KEY    = 8'h01;
  localparam logic [7:0] PHASE_PRESS = 8'h00;
  localparam logic [7:0] MODE_NONE   = 8'h06;
  localparam logic [7:0] MODE_TOP    = 8'hFF;
  localparam int         PHASES      = 8;
  localparam int         PHASE_ITEMS = 203;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_cmd_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_res_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int mismatches, outstanding, n_accepted, n_forwarded, n_index_err;

  logic       calm       = 1'b0;
  logic [7:0] anchor_ms  = '0;
  logic [6:0] cur_min    = MIN_INTERVAL_RST;
  int         n_sent     = 0;
  int         n_settings = 1;
  int         stall_left = 0;

  always #10 clk = ~clk;

  led_brightness_command_engine dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  lbce_result_checker result_check (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .outstanding, .n_accepted, .n_forwarded, .n_index_err
  );

  // result side: rare random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(99) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic issue(input in_cmd_t c);
    in_data  <= c;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    // track the last time stamp that got through so timed words keep passing
    if (!(c.trigger_kind == KIND_QUERY && c.trigger_phase == PHASE_QUERY) &&
        !(c.trigger_kind == KIND_SWITCH && c.trigger_phase == PHASE_RELEASE) &&
        7'(c.now_ms - anchor_ms) >= cur_min)
      anchor_ms = c.now_ms;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_MIN_INTERVAL) cur_min = val[6:0];
  endtask

  // unused upper data bits carry noise; a spare index is written as well
  task automatic set_config(input logic fwd, input logic [6:0] min_ms);
    write_reg(REG_FORWARD_ENABLE, {7'($urandom), fwd});
    write_reg(REG_MIN_INTERVAL, {1'($urandom), min_ms});
    write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, REG_MIN_INTERVAL + 1)),
              CFG_DATA_W'($urandom));
    n_settings++;
  endtask

  function automatic in_cmd_t random_cmd();
    in_cmd_t c;
    int      r;
    int      r2;
    c  = in_cmd_t'({$urandom, $urandom});
    r  = $urandom_range(99);
    if (r < 80)
      c.now_ms = anchor_ms + 8'(cur_min) + 8'($urandom_range(127 - cur_min));
    r = $urandom_range(99);
    if (r < 8) begin
      c.trigger_kind  = KIND_SWITCH;
      c.trigger_phase = PHASE_RELEASE;
    end else if (r < 12) begin
      c.trigger_kind  = KIND_QUERY;
      c.trigger_phase = PHASE_QUERY;
    end else if (r < 35) begin
      c.trigger_kind = KIND_SWITCH;
    end
    r  = $urandom_range(99);
    r2 = $urandom_range(99);
    if (r < 35) begin
      c.mode  = 8'($urandom_range(MODE_SET_ONE));
      c.index = 16'($urandom_range(CHANNELS - 1));
    end else if (r < 50) begin
      c.mode  = 8'($urandom_range(MODE_SET_ONE));
      c.index = (r2 < 50) ? 16'(CHANNELS + $urandom_range(15))
                          : 16'($urandom_range(65535, CHANNELS));
    end else if (r < 70) begin
      c.mode = 8'($urandom_range(MODE_SET_ALL, MODE_DEC_ALL));
      if (r2 < 70) c.index = 16'($urandom_range(CHANNELS - 1));
    end else if (r < 82) begin
      c.mode = 8'($urandom_range(255, MODE_SET_ALL + 1));
    end else begin
      c.mode = 8'($urandom_range(MODE_SET_ALL));
    end
    r = $urandom_range(99);
    if (r < 10) c.amount = 8'h00;
    else if (r < 20) c.amount = 8'hFF;
    return c;
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register values as after reset: no forwarding, 30 ms interval
    issue({8'd30,  KIND_KEY, PHASE_PRESS, MODE_SET_ONE, 8'd255, 16'd0});
    issue({8'd40,  KIND_KEY, PHASE_PRESS, MODE_INC_ONE, 8'd1, 16'd0});      // too soon
    issue({8'd100, KIND_SWITCH, PHASE_RELEASE, MODE_SET_ALL, 8'd7, 16'd0});
    issue({8'd100, KIND_QUERY, PHASE_QUERY, MODE_SET_ALL, 8'd7, 16'd0});
    issue({8'd100, KIND_SWITCH, PHASE_PRESS, MODE_INC_ONE, 8'd1, 16'd0});   // wraps to 0
    issue({8'd130, KIND_KEY, PHASE_PRESS, MODE_DEC_ONE, 8'd1, 16'd143});    // wraps to 255
    issue({8'd160, KIND_KEY, PHASE_PRESS, MODE_SET_ONE, 8'd9, 16'd144});
    issue({8'd190, KIND_KEY, PHASE_PRESS, MODE_DEC_ONE, 8'd1, 16'hFFFF});
    issue({8'd220, KIND_KEY, PHASE_PRESS, MODE_NONE, 8'd5, 16'd143});
    issue({8'd250, KIND_KEY, PHASE_PRESS, MODE_TOP, 8'd5, 16'hFFFF});
    issue({8'd24,  KIND_KEY, PHASE_PRESS, MODE_SET_ALL, 8'd128, 16'd5});    // time wraps
    issue({8'd54,  KIND_KEY, PHASE_PRESS, MODE_INC_ALL, 8'd255, 16'd200});
    issue({8'd84,  KIND_KEY, PHASE_PRESS, MODE_DEC_ALL, 8'd129, 16'd143});
    wait_idle();

    write_reg(REG_FORWARD_ENABLE, 8'hFF);
    write_reg(REG_MIN_INTERVAL, 8'h80);
    n_settings++;
    issue({8'h00, KIND_KEY, PHASE_PRESS, MODE_SET_ONE, 8'd1, 16'd144});
    issue({8'h10, KIND_KEY, PHASE_PRESS, MODE_INC_ONE, 8'd2, 16'hFFFF});
    issue({8'h20, KIND_KEY, PHASE_PRESS, MODE_DEC_ONE, 8'd3, 16'd143});
    issue({8'h30, KIND_KEY, PHASE_PRESS, MODE_SET_ALL, 8'hAA, 16'hFFFF});
    issue({8'h40, KIND_KEY, PHASE_PRESS, MODE_INC_ALL, 8'h55, 16'd0});
    issue({8'h50, KIND_KEY, PHASE_PRESS, 8'h80, 8'd1, 16'd300});
    issue({8'h50, KIND_KEY, PHASE_PRESS, MODE_INC_ONE, 8'd1, 16'd1});       // zero gap
    issue({8'h60, KIND_SWITCH, PHASE_RELEASE, MODE_INC_ONE, 8'd1, 16'd1});
    wait_idle();

    write_reg(REG_MIN_INTERVAL, 8'h7F);
    n_settings++;
    issue({8'hCE, KIND_KEY, PHASE_PRESS, MODE_SET_ONE, 8'd1, 16'd2});       // one short
    issue({8'hCF, KIND_KEY, PHASE_PRESS, MODE_SET_ONE, 8'd1, 16'd2});
    issue({8'h4F, KIND_KEY, PHASE_PRESS, MODE_SET_ONE, 8'd1, 16'd2});       // 128 ms aliases to 0

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0:       set_config(1'b1, 7'd0);
        1:       set_config(1'b0, 7'd127);
        2:       set_config(1'b1, 7'd127);
        3:       set_config(1'b0, MIN_INTERVAL_RST);
        4:       set_config(1'b1, 7'($urandom));
        5:       set_config(1'b0, 7'd0);
        default: set_config(1'($urandom), 7'($urandom));
      endcase
      calm <= (ph == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 100 == 99) begin
          wait_idle();
        end else if (!calm && $urandom_range(99) < 6) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        issue(random_cmd());
      end
    end

    wait_idle();
    repeat (160) @(posedge clk);
    $display("Ran %0d command words over %0d register settings", n_sent, n_settings);
    $display("  %0d accepted, %0d forwarded, %0d bad local indexes", n_accepted,
             n_forwarded, n_index_err);
    if (outstanding != 0) $display("%0d result words never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #25ms;
    $display("Timeout: engine stopped responding");
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/lbce_pkg.sv
rtl/core/led_brightness_command_engine.sv
rtl/core/lbce_checker.sv
sim/lbce_result_checker.sv
sim/testbench.sv
